[hw/rtl/cdtb_pkg.sv]
package cdtb_pkg;

  localparam int unsigned SlotLimit = 16;
  localparam int unsigned ActW      = 3;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned CountW    = 32;

  typedef enum logic [ActW-1:0] {
    ACT_TICK         = 3'd0,
    ACT_START        = 3'd1,
    ACT_STOP         = 3'd2,
    ACT_SET_COUNT    = 3'd3,
    ACT_SET_INTERVAL = 3'd4,
    ACT_EXTEND       = 3'd5,
    ACT_READ         = 3'd6
  } action_e;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [SlotW-1:0]  timer_index;
    logic [CountW-1:0] amount;
  } in_req_t;

  typedef struct packed {
    logic              kind;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] remaining;
    logic              last;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic expire;
    logic pend_valid;
    logic walk_last;
    logic item_read;
  } dp_status_t;

endpackage

[hw/rtl/cdtb_ctrl.sv]
module cdtb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_tick_i,
  output logic                 in_stall_o,
  input  cdtb_pkg::dp_status_t status_i,
  output cdtb_pkg::dp_cmd_t    cmd_o
);
  import cdtb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = in_tick_i ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a read needs the output register free
        if (!status_i.item_read || status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_WALK: begin
        // a second expiry pushes the pending one out, so wait for room
        if (!(status_i.expire && status_i.pend_valid && !status_i.out_free)) begin
          cmd_o.step = 1'b1;
          if (status_i.walk_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

[hw/rtl/cdtb_dp.sv]
module cdtb_dp #(
  parameter int unsigned TIMERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cdtb_pkg::in_req_t  in_req_i,
  input  cdtb_pkg::dp_cmd_t  cmd_i,
  output cdtb_pkg::dp_status_t status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdtb_pkg::out_rsp_t out_rsp_o
);
  import cdtb_pkg::*;

  localparam int unsigned WalkLen = (TIMERS < SlotLimit) ? TIMERS : SlotLimit;
  localparam int unsigned IdxW    = (WalkLen > 1) ? $clog2(WalkLen) : 1;

  logic [CountW-1:0]  count_q  [WalkLen];
  logic [CountW-1:0]  reload_q [WalkLen];
  logic [WalkLen-1:0] run_q;

  in_req_t        item_q;
  logic [IdxW-1:0] slot_q;   // walk position on a tick, target slot otherwise
  out_rsp_t       pend_q, out_q;
  logic           pend_valid_q, out_valid_q;

  logic [CountW-1:0] cur_count, cur_reload, cur_dec, ext_val;
  logic [CountW:0]   ext_sum;
  logic              cur_run, cur_expire, item_ok, out_free;

  assign cur_count  = count_q[slot_q];
  assign cur_reload = reload_q[slot_q];
  assign cur_run    = run_q[slot_q];
  assign cur_dec    = (cur_count != '0) ? cur_count - 1'b1 : '0;
  assign cur_expire = cur_run && (cur_dec == '0);

  assign ext_sum = {1'b0, cur_count} + {1'b0, item_q.amount};
  assign ext_val = ext_sum[CountW] ? '1 : ext_sum[CountW-1:0];

  assign item_ok  = ({1'b0, item_q.timer_index} < (SlotW+1)'(WalkLen));
  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.out_free   = out_free;
  assign status_o.expire     = cur_expire;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.walk_last  = (slot_q == IdxW'(WalkLen - 1));
  assign status_o.item_read  = (item_q.action == ACT_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WalkLen; i++) begin
        count_q[i]  <= '0;
        reload_q[i] <= '0;
      end
      run_q        <= '0;
      slot_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        slot_q <= (in_req_i.action == ACT_TICK) ? '0 : in_req_i.timer_index[IdxW-1:0];
      end
      if (cmd_i.exec) begin
        if (item_ok) begin
          case (item_q.action)
            ACT_START:        run_q[slot_q]    <= 1'b1;
            ACT_STOP:         run_q[slot_q]    <= 1'b0;
            ACT_SET_COUNT:    count_q[slot_q]  <= item_q.amount;
            ACT_SET_INTERVAL: reload_q[slot_q] <= item_q.amount;
            ACT_EXTEND:       count_q[slot_q]  <= ext_val;
            default: ;
          endcase
        end
        if (item_q.action == ACT_READ) begin
          out_valid_q <= 1'b1;
        end
      end
      if (cmd_i.step) begin
        if (cur_run) begin
          count_q[slot_q] <= cur_expire ? cur_reload : cur_dec;
          run_q[slot_q]   <= cur_expire ? (cur_reload != '0) : 1'b1;
        end
        if (cur_expire) begin
          if (pend_valid_q) begin
            out_valid_q <= 1'b1;
          end
          pend_valid_q <= 1'b1;
        end
        slot_q <= slot_q + 1'b1;
      end
      if (cmd_i.flush && pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_req_i;
    end
    if (cmd_i.exec && (item_q.action == ACT_READ)) begin
      out_q.kind      <= KIND_READ;
      out_q.slot      <= item_q.timer_index;
      out_q.remaining <= item_ok ? cur_count : '0;
      out_q.last      <= 1'b1;
    end
    if (cmd_i.step && cur_expire) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end
      pend_q.kind      <= KIND_EXPIRY;
      pend_q.slot      <= SlotW'(slot_q);
      pend_q.remaining <= cur_reload;
      pend_q.last      <= 1'b0;
    end
    // the held expiry is the final one of the tick
    if (cmd_i.flush && pend_valid_q) begin
      out_q.kind      <= pend_q.kind;
      out_q.slot      <= pend_q.slot;
      out_q.remaining <= pend_q.remaining;
      out_q.last      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[hw/rtl/countdown_timer_bank_top.sv]
// Bank of countdown timer slots.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per item, either
// a tick or an action (start, stop, set count, set interval, extend, read) on
// the slot in timer_index. Output channel (out_valid_o / out_stall_i /
// out_rsp_o): expiry results of a tick in slot order, or one read result;
// last marks the final result of a request.
// One request is in flight at a time; in_stall_o is high while it is worked.
// Slot actions are accepted, then executed. A tick is accepted, then walks
// min(TIMERS,16) slots, one per cycle unless paused, through the single
// slot read/update port, and a final step releases the held last expiry.
// A read result appears in the output register in the cycle after execute.
// Expiries are held one deep so that last can be set on the final one; the
// walk pauses while a second expiry meets a full, stalled output register.
// A stalled result stays in the output register unchanged.
// Reset clears every count, interval and running flag and empties the
// output; no clearing pass is needed.
module countdown_timer_bank_top #(
  parameter int unsigned TIMERS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cdtb_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cdtb_pkg::out_rsp_t out_rsp_o
);
  import cdtb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cdtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_tick_i  (in_req_i.action == ACT_TICK),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cdtb_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

[bench/tb_countdown_timer_bank_top.sv]
module tb_countdown_timer_bank_top;
  import cdtb_pkg::*;

  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned WALK = (NUM_TIMERS < SlotLimit) ? NUM_TIMERS : SlotLimit;
  localparam logic [ActW-1:0] ACT_UNUSED = 3'd7;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  countdown_timer_bank_top #(
    .TIMERS(NUM_TIMERS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Timer bank state as the block should hold it
  logic [CountW-1:0] slot_count  [WALK];
  logic [CountW-1:0] slot_reload [WALK];
  logic              slot_on     [WALK];

  out_rsp_t step_results[$];
  out_rsp_t pending_results[$];
  int       mismatches = 0;
  int       send_idle_pct = 17;
  int       recv_stall_pct = 71;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } stim_row_t;

  stim_row_t stim_table[$];

  // Applies one request to the bank state, leaves its results in step_results
  function automatic void predict_timer_results(in_req_t r);
    logic [SlotW-1:0] idx;
    bit               reach;
    out_rsp_t         res;
    idx   = r.timer_index;
    reach = idx < WALK;
    step_results.delete();
    case (r.action)
      ACT_TICK: begin
        for (int i = 0; i < WALK; i++) begin
          if (slot_on[i]) begin
            if (slot_count[i] != '0) slot_count[i] = slot_count[i] - 1'b1;
            if (slot_count[i] == '0) begin
              slot_count[i] = slot_reload[i];
              slot_on[i]    = slot_reload[i] != '0;
              res.kind      = KIND_EXPIRY;
              res.slot      = i[SlotW-1:0];
              res.remaining = slot_count[i];
              res.last      = 1'b0;
              step_results  = {step_results, res};
            end
          end
        end
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      end
      ACT_START: if (reach) slot_on[idx] = 1'b1;
      ACT_STOP: if (reach) slot_on[idx] = 1'b0;
      ACT_SET_COUNT: if (reach) slot_count[idx] = r.amount;
      ACT_SET_INTERVAL: if (reach) slot_reload[idx] = r.amount;
      ACT_EXTEND: begin
        if (reach) begin
          if (slot_count[idx] > COUNT_MAX - r.amount) slot_count[idx] = COUNT_MAX;
          else slot_count[idx] = slot_count[idx] + r.amount;
        end
      end
      ACT_READ: begin
        res.kind      = KIND_READ;
        res.slot      = idx;
        res.remaining = reach ? slot_count[idx] : '0;
        res.last      = 1'b1;
        step_results  = {step_results, res};
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [ActW-1:0] act, logic [SlotW-1:0] idx,
                                  logic [CountW-1:0] amt, bit typed = 1'b0,
                                  logic kind = KIND_EXPIRY, logic [SlotW-1:0] slot = '0,
                                  logic [CountW-1:0] rem = '0);
    stim_row_t row;
    row.req.action      = act;
    row.req.timer_index = idx;
    row.req.amount      = amt;
    row.typed           = typed;
    row.rsp.kind        = kind;
    row.rsp.slot        = slot;
    row.rsp.remaining   = rem;
    row.rsp.last        = 1'b1;
    stim_table          = {stim_table, row};
  endfunction

  function automatic logic [CountW-1:0] random_amount();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return $urandom_range(4);
    if (sel < 8) return $urandom;
    return COUNT_MAX - $urandom_range(3);
  endfunction

  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    pick          = $urandom_range(99);
    r.timer_index = $urandom_range(1) ? SlotW'($urandom_range(3)) : SlotW'($urandom_range(15));
    r.amount      = random_amount();
    if (pick < 38)      r.action = ACT_TICK;
    else if (pick < 50) r.action = ACT_START;
    else if (pick < 55) r.action = ACT_STOP;
    else if (pick < 67) r.action = ACT_SET_COUNT;
    else if (pick < 78) r.action = ACT_SET_INTERVAL;
    else if (pick < 85) r.action = ACT_EXTEND;
    else if (pick < 98) r.action = ACT_READ;
    else                r.action = ACT_UNUSED;
    return r;
  endfunction

  // Returns at the edge where the request is taken
  task automatic offer_request(in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic issue_random(in_req_t r);
    offer_request(r);
    predict_timer_results(r);
    foreach (step_results[k]) pending_results = {pending_results, step_results[k]};
  endtask

  function automatic void check_result(out_rsp_t got);
    out_rsp_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d slot %0d remaining %0d", got.kind, got.slot,
             got.remaining);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      mismatches++;
    end
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      mismatches++;
    end
    if (got.remaining !== want.remaining) begin
      $error("remaining: expected 0x%08h, got 0x%08h", want.remaining, got.remaining);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_rsp_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    int      guard;
    in_req_t req;
    logic [SlotW-1:0] arm_slot;

    foreach (slot_count[i]) begin
      slot_count[i]  = '0;
      slot_reload[i] = '0;
      slot_on[i]     = 1'b0;
    end

    add_row(ACT_READ, 4'd0, '0, 1'b1, KIND_READ, 4'd0, '0);
    add_row(ACT_READ, 4'd15, COUNT_MAX, 1'b1, KIND_READ, 4'd15, '0);
    add_row(ACT_TICK, 4'd0, '0);
    add_row(ACT_SET_COUNT, 4'd0, 32'd1);
    add_row(ACT_SET_INTERVAL, 4'd0, 32'd3);
    add_row(ACT_START, 4'd0, '0);
    add_row(ACT_TICK, 4'd9, '0, 1'b1, KIND_EXPIRY, 4'd0, 32'd3);
    add_row(ACT_SET_COUNT, 4'd15, COUNT_MAX);
    add_row(ACT_EXTEND, 4'd15, 32'd5);
    add_row(ACT_READ, 4'd15, '0, 1'b1, KIND_READ, 4'd15, COUNT_MAX);
    // slot 5 runs with zero count and zero interval: fires once, then stops
    add_row(ACT_START, 4'd5, '0);
    add_row(ACT_TICK, 4'd0, '0, 1'b1, KIND_EXPIRY, 4'd5, '0);
    add_row(ACT_TICK, 4'd0, '0);
    add_row(ACT_TICK, 4'd0, '0, 1'b1, KIND_EXPIRY, 4'd0, 32'd3);
    add_row(ACT_SET_COUNT, 4'd7, 32'hA5A5_5A5A);
    add_row(ACT_EXTEND, 4'd7, 32'h5A5A_A5A5);
    add_row(ACT_READ, 4'd7, '0, 1'b1, KIND_READ, 4'd7, COUNT_MAX);
    add_row(ACT_EXTEND, 4'd7, 32'd1);
    add_row(ACT_READ, 4'd7, '0, 1'b1, KIND_READ, 4'd7, COUNT_MAX);
    add_row(ACT_UNUSED, 4'd3, COUNT_MAX);
    add_row(ACT_SET_COUNT, 4'd3, 32'd1);
    add_row(ACT_START, 4'd3, '0);
    add_row(ACT_SET_INTERVAL, 4'd15, COUNT_MAX);
    add_row(ACT_START, 4'd15, '0);
    add_row(ACT_TICK, 4'd0, '0, 1'b1, KIND_EXPIRY, 4'd3, '0);
    add_row(ACT_STOP, 4'd0, '0);
    add_row(ACT_READ, 4'd15, '0, 1'b1, KIND_READ, 4'd15, 32'hFFFF_FFFE);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[n]) begin
      offer_request(stim_table[n].req);
      predict_timer_results(stim_table[n].req);
      if (stim_table[n].typed) pending_results = {pending_results, stim_table[n].rsp};
      else foreach (step_results[k]) pending_results = {pending_results, step_results[k]};
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 17 : (ph == 1) ? 71 : 0;
      recv_stall_pct = (ph == 0) ? 71 : (ph == 1) ? 17 : 0;
      repeat (36) begin
        if ($urandom_range(4) == 0) begin
          // arm a slot with a short count and a short period
          arm_slot       = SlotW'($urandom_range(15));
          req.timer_index = arm_slot;
          req.action     = ACT_SET_COUNT;
          req.amount     = $urandom_range(3);
          issue_random(req);
          req.action     = ACT_SET_INTERVAL;
          req.amount     = $urandom_range(3);
          issue_random(req);
          req.action     = ACT_START;
          req.amount     = $urandom;
          issue_random(req);
        end else begin
          issue_random(random_request());
        end
      end
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
